@@ sv/lpc_pkg.sv @@
// shared types, codes and constants of the line printer canonicalizer
package lpc_pkg;

    // request commands
    localparam logic [1:0] CMD_CHAR  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PAGE_LINES   = 2'd0;
    localparam logic [1:0] CFG_LINE_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_AUTO_EJECT   = 2'd2;
    localparam logic [1:0] CFG_RAW_MODE     = 2'd3;

    localparam logic [7:0] PAGE_LINES_RST   = 8'd60;
    localparam logic [7:0] LINE_COLUMNS_RST = 8'd132;

    // character codes
    localparam logic [6:0] CH_PLOT = 7'h05;
    localparam logic [6:0] CH_BS   = 7'h08;
    localparam logic [6:0] CH_TAB  = 7'h09;
    localparam logic [6:0] CH_NL   = 7'h0A;
    localparam logic [6:0] CH_VT   = 7'h0B;
    localparam logic [6:0] CH_FF   = 7'h0C;
    localparam logic [6:0] CH_CR   = 7'h0D;
    localparam logic [6:0] CH_SO   = 7'h0E;
    localparam logic [6:0] CH_SP   = 7'h20;

    localparam logic [9:0] COL_MAX   = 10'd1023;
    localparam logic [9:0] LINE_MAX  = 10'd1023;
    localparam logic [7:0] RUN_LIMIT = 8'h81;
    localparam logic [3:0] MAX_OUT   = 4'd10;

    typedef enum logic [2:0] {
        CL_TAB,
        CL_LINE,
        CL_CR,
        CL_SO,
        CL_BS,
        CL_SP,
        CL_PLOT,
        CL_PRINT
    } t_ch_class;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OPEN_INIT,
        OP_SET_FF,
        OP_CLOSE_FIN,
        OP_TAB,
        OP_LINE,
        OP_CR,
        OP_SO,
        OP_BS,
        OP_SP,
        OP_PLOT,
        OP_PRE,
        OP_PAD,
        OP_CHAR,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CANON,
        ST_CRST,
        ST_PAD,
        ST_END,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       busy;
        logic       fin_ok;
        logic       job_open;
        logic       auto_eject;
        logic [1:0] cmd;
        t_ch_class  cls;
        logic       lt_cols;
        logic       pad_more;
    } t_dp_status;

    function automatic t_ch_class ch_class(input logic [6:0] c);
        t_ch_class cl;
        unique case (c)
            CH_TAB:               cl = CL_TAB;
            CH_VT, CH_FF, CH_NL:  cl = CL_LINE;
            CH_CR:                cl = CL_CR;
            CH_SO:                cl = CL_SO;
            CH_BS:                cl = CL_BS;
            CH_SP:                cl = CL_SP;
            CH_PLOT:              cl = CL_PLOT;
            default:              cl = CL_PRINT;
        endcase
        return cl;
    endfunction

endpackage

@@ sv/lpc_datapath.sv @@
// datapath: page state, run-length packer, byte staging and output register
module lpc_datapath
    import lpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic [1:0] i_command,
    input  logic [6:0] i_char_code,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output logic [7:0] o_queue_byte,
    output logic       o_last
);

    logic [7:0] r_page_lines, n_page_lines;
    logic [7:0] r_line_columns, n_line_columns;
    logic       r_auto_eject, n_auto_eject;
    logic       r_raw_mode, n_raw_mode;
    logic [9:0] r_logical, n_logical;
    logic [7:0] r_printed, n_printed;
    logic [9:0] r_line, n_line;
    logic       r_top, n_top;
    logic       r_job, n_job;
    logic       r_plot, n_plot;
    logic [7:0] r_last_byte, n_last_byte;
    logic [7:0] r_pend, n_pend;
    logic       r_q0v, n_q0v;
    logic       r_q1v, n_q1v;
    logic       r_hold_v, n_hold_v;
    logic       r_out_v, n_out_v;
    logic [3:0] r_put_cnt, n_put_cnt;
    // payload
    logic [1:0] r_cmd, n_cmd;
    logic [6:0] r_ch, n_ch;
    logic [7:0] r_q0, n_q0;
    logic [7:0] r_q1, n_q1;
    logic [7:0] r_hold, n_hold;
    logic [7:0] r_out, n_out;
    logic       r_out_last, n_out_last;

    // line motion
    logic       ln_vt;
    logic [6:0] ln_cf;
    logic [6:0] ln_cf2;
    logic       ln_go;
    logic       ln_ff;
    logic [9:0] ln_line1;

    // emit
    logic       em_req;
    logic [7:0] em_byte;
    logic       em_eq;
    logic [7:0] em_dec;
    logic       em_hold;
    logic [7:0] em_cnt;

    logic        lt_cols;
    logic        pad_more;
    logic [10:0] tab_sum;
    logic [10:0] tab_t;
    logic        out_free;
    logic        can_put;
    logic [7:0]  q_sel;

    assign lt_cols  = r_logical < {2'b00, r_line_columns};
    assign pad_more = r_logical > {2'b00, r_printed};
    assign out_free = !r_out_v || !i_out_stall;
    assign can_put  = (r_put_cnt >= MAX_OUT) || !r_hold_v || out_free;
    assign q_sel    = r_q0v ? r_q0 : r_q1;
    assign tab_sum  = {1'b0, r_logical} + 11'd8;
    assign tab_t    = tab_sum & ~11'd7;

    assign ln_vt = (r_ch == CH_VT);
    assign ln_cf = (ln_vt && r_line > {3'b000, r_page_lines[7:1]}) ? CH_FF : r_ch;
    assign ln_go = !r_top || r_raw_mode;

    always_comb begin
        ln_line1 = r_line;
        if (!r_plot) begin
            if (!ln_vt && r_line != LINE_MAX) begin
                ln_line1 = r_line + 10'd1;
            end
        end else if (ln_vt && r_line != 10'd0) begin
            ln_line1 = r_line - 10'd1;
        end
    end

    assign ln_cf2 = (ln_line1 >= {2'b00, r_page_lines} && r_auto_eject && r_job)
                    ? CH_FF : ln_cf;
    assign ln_ff  = (ln_cf2 == CH_FF);

    always_comb begin
        em_req  = 1'b0;
        em_byte = {1'b0, r_ch};
        case (i_op)
            OP_LINE: begin
                em_req  = ln_go;
                em_byte = {1'b0, ln_cf2};
            end
            OP_CR: begin
                em_req  = (r_printed != 8'd0);
                em_byte = {1'b0, CH_CR};
            end
            OP_SO: begin
                em_req  = 1'b1;
                em_byte = {1'b0, CH_BS};
            end
            OP_PLOT: begin
                em_req  = 1'b1;
                em_byte = {1'b0, CH_PLOT};
            end
            OP_PRE: begin
                em_req  = r_logical < {2'b00, r_printed};
                em_byte = {1'b0, CH_CR};
            end
            OP_PAD: begin
                em_req  = 1'b1;
                em_byte = {1'b0, CH_SP};
            end
            OP_CHAR: begin
                em_req  = lt_cols;
                em_byte = {1'b0, r_ch};
            end
            default: begin
                em_req = 1'b0;
            end
        endcase
    end

    // a repeat of the previous byte only bumps the count until the limit
    assign em_eq   = (em_byte == r_last_byte);
    assign em_dec  = r_pend - 8'd1;
    assign em_hold = em_eq && (em_dec != RUN_LIMIT);
    assign em_cnt  = em_eq ? em_dec : r_pend;

    always_comb begin
        n_page_lines   = r_page_lines;
        n_line_columns = r_line_columns;
        n_auto_eject   = r_auto_eject;
        n_raw_mode     = r_raw_mode;
        n_logical      = r_logical;
        n_printed      = r_printed;
        n_line         = r_line;
        n_top          = r_top;
        n_job          = r_job;
        n_plot         = r_plot;
        n_last_byte    = r_last_byte;
        n_pend         = r_pend;
        n_q0v          = r_q0v;
        n_q1v          = r_q1v;
        n_hold_v       = r_hold_v;
        n_out_v        = r_out_v && i_out_stall;
        n_put_cnt      = r_put_cnt;
        n_cmd          = r_cmd;
        n_ch           = r_ch;
        n_q0           = r_q0;
        n_q1           = r_q1;
        n_hold         = r_hold;
        n_out          = r_out;
        n_out_last     = r_out_last;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAGE_LINES:   n_page_lines   = i_cfg_data;
                CFG_LINE_COLUMNS: n_line_columns = i_cfg_data;
                CFG_AUTO_EJECT:   n_auto_eject   = i_cfg_data[0];
                CFG_RAW_MODE:     n_raw_mode     = i_cfg_data[0];
                default:          n_raw_mode     = r_raw_mode;
            endcase
        end

        // staged bytes move on one a cycle while the output can take them, the last one held back for its flag
        if ((r_q0v || r_q1v) && can_put) begin
            if (r_q0v) begin
                n_q0v = 1'b0;
            end else begin
                n_q1v = 1'b0;
            end
            if (r_put_cnt < MAX_OUT) begin
                if (r_hold_v) begin
                    n_out_v    = 1'b1;
                    n_out      = r_hold;
                    n_out_last = 1'b0;
                end
                n_hold_v  = 1'b1;
                n_hold    = q_sel;
                n_put_cnt = r_put_cnt + 4'd1;
            end
        end

        if (em_req) begin
            if (em_hold) begin
                n_pend = em_dec;
            end else begin
                n_last_byte = em_byte;
                n_top       = 1'b0;
                n_pend      = 8'd0;
                n_q0v       = (em_cnt != 8'd0);
                n_q0        = em_cnt;
                n_q1v       = 1'b1;
                n_q1        = em_byte;
            end
        end

        case (i_op)
            OP_LOAD: begin
                n_cmd     = i_command;
                n_ch      = i_char_code;
                n_put_cnt = 4'd0;
            end
            OP_OPEN_INIT: begin
                n_job     = 1'b1;
                n_top     = r_auto_eject;
                n_plot    = 1'b0;
                n_pend    = 8'd0;
                n_line    = 10'd0;
                n_printed = 8'd0;
                n_ch      = CH_FF;
            end
            OP_SET_FF: begin
                n_ch = CH_FF;
            end
            OP_CLOSE_FIN: begin
                n_job = 1'b0;
                n_top = 1'b0;
            end
            OP_TAB: begin
                n_logical = (tab_t > {1'b0, COL_MAX}) ? COL_MAX : tab_t[9:0];
            end
            OP_LINE: begin
                if (ln_go) begin
                    n_printed = 8'd0;
                    if (ln_ff) begin
                        n_line = 10'd0;
                        n_top  = 1'b1;
                    end else begin
                        n_line = ln_line1;
                    end
                end else if (ln_vt && r_line != 10'd0) begin
                    n_line = r_line - 10'd1;
                end
            end
            OP_CR: begin
                n_plot    = 1'b0;
                n_printed = 8'd0;
                n_logical = 10'd0;
            end
            OP_BS: begin
                if (r_logical != 10'd0) begin
                    n_logical = r_logical - 10'd1;
                end
            end
            OP_SP: begin
                if (r_logical != COL_MAX) begin
                    n_logical = r_logical + 10'd1;
                end
            end
            OP_PLOT: begin
                n_plot = 1'b1;
            end
            OP_PRE: begin
                if (r_logical < {2'b00, r_printed}) begin
                    n_printed = 8'd0;
                end
            end
            OP_PAD: begin
                n_printed = r_printed + 8'd1;
            end
            OP_CHAR: begin
                if (lt_cols) begin
                    n_printed = r_printed + 8'd1;
                end
                if (r_logical != COL_MAX) begin
                    n_logical = r_logical + 10'd1;
                end
            end
            OP_FINISH: begin
                if (r_hold_v) begin
                    n_out_v    = 1'b1;
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                end
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_lines   <= PAGE_LINES_RST;
            r_line_columns <= LINE_COLUMNS_RST;
            r_auto_eject   <= 1'b1;
            r_raw_mode     <= 1'b0;
            r_logical      <= 10'd0;
            r_printed      <= 8'd0;
            r_line         <= 10'd0;
            r_top          <= 1'b0;
            r_job          <= 1'b0;
            r_plot         <= 1'b0;
            r_last_byte    <= 8'd0;
            r_pend         <= 8'd0;
            r_q0v          <= 1'b0;
            r_q1v          <= 1'b0;
            r_hold_v       <= 1'b0;
            r_out_v        <= 1'b0;
            r_put_cnt      <= 4'd0;
        end else begin
            r_page_lines   <= n_page_lines;
            r_line_columns <= n_line_columns;
            r_auto_eject   <= n_auto_eject;
            r_raw_mode     <= n_raw_mode;
            r_logical      <= n_logical;
            r_printed      <= n_printed;
            r_line         <= n_line;
            r_top          <= n_top;
            r_job          <= n_job;
            r_plot         <= n_plot;
            r_last_byte    <= n_last_byte;
            r_pend         <= n_pend;
            r_q0v          <= n_q0v;
            r_q1v          <= n_q1v;
            r_hold_v       <= n_hold_v;
            r_out_v        <= n_out_v;
            r_put_cnt      <= n_put_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ch       <= n_ch;
        r_q0       <= n_q0;
        r_q1       <= n_q1;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_status.busy       = r_q0v || r_q1v;
    assign o_status.fin_ok     = !r_hold_v || out_free;
    assign o_status.job_open   = r_job;
    assign o_status.auto_eject = r_auto_eject;
    assign o_status.cmd        = r_cmd;
    assign o_status.cls        = ch_class(r_ch);
    assign o_status.lt_cols    = lt_cols;
    assign o_status.pad_more   = pad_more;

    assign o_out_valid  = r_out_v;
    assign o_queue_byte = r_out;
    assign o_last       = r_out_last;

endmodule

@@ sv/lpc_ctrl.sv @@
// controller: steps one request through the canonicalizer datapath
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_op        o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.cmd == CMD_CHAR && i_status.job_open) begin
                    n_state = ST_CANON;
                end else if (i_status.cmd == CMD_OPEN && !i_status.job_open) begin
                    o_op    = OP_OPEN_INIT;
                    n_state = i_status.auto_eject ? ST_CANON : ST_FINISH;
                end else if (i_status.cmd == CMD_CLOSE && i_status.job_open) begin
                    if (i_status.auto_eject) begin
                        o_op    = OP_SET_FF;
                        n_state = ST_CANON;
                    end else begin
                        n_state = ST_END;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_CANON: begin
                if (!i_status.busy) begin
                    unique case (i_status.cls)
                        CL_TAB: begin
                            o_op    = OP_TAB;
                            n_state = ST_END;
                        end
                        CL_LINE: begin
                            o_op    = OP_LINE;
                            n_state = ST_CRST;
                        end
                        CL_CR: begin
                            n_state = ST_CRST;
                        end
                        CL_SO: begin
                            o_op    = OP_SO;
                            n_state = ST_END;
                        end
                        CL_BS: begin
                            o_op    = OP_BS;
                            n_state = ST_END;
                        end
                        CL_SP: begin
                            o_op    = OP_SP;
                            n_state = ST_END;
                        end
                        CL_PLOT: begin
                            o_op    = OP_PLOT;
                            n_state = ST_END;
                        end
                        default: begin
                            o_op    = OP_PRE;
                            n_state = ST_PAD;
                        end
                    endcase
                end
            end
            ST_CRST: begin
                if (!i_status.busy) begin
                    o_op    = OP_CR;
                    n_state = ST_END;
                end
            end
            ST_PAD: begin
                // one padding space per step, within the line columns, until the printed column catches up
                if (!i_status.busy) begin
                    if (i_status.lt_cols && i_status.pad_more) begin
                        o_op = OP_PAD;
                    end else begin
                        o_op    = OP_CHAR;
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (!i_status.busy) begin
                    if (i_status.cmd == CMD_CLOSE) begin
                        o_op = OP_CLOSE_FIN;
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.busy && i_status.fin_ok) begin
                    o_op    = OP_FINISH;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/line_printer_canonicalizer.sv @@
// top level of the line printer canonicalizer with run-length packing
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid/o_in_stall   i_command, i_char_code
//  output    out        o_out_valid/i_out_stall o_queue_byte, o_last
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// one request at a time: load, dispatch and finish, the controller steps, one step
// per padding space, and the staging path moves a single byte a cycle while the
// output is not stalled.
// reset is synchronous, active low; configuration returns to 60 lines, 132 columns.
// a stalled output holds its byte; the final byte of a request waits there while
// the next request is taken.
module line_printer_canonicalizer
    import lpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [6:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_queue_byte,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_op        op;
    t_dp_status status;

    lpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_op       (op)
    );

    lpc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_queue_byte (o_queue_byte),
        .o_last       (o_last)
    );

endmodule

@@ sim/line_printer_canonicalizer_tb.sv @@
// self-checking testbench for the line printer canonicalizer
`timescale 1ns / 100ps

module line_printer_canonicalizer_tb;
    import lpc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] qbyte;
        logic       last;
    } t_queue_entry;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_command = CMD_CHAR;
    logic [6:0] i_char_code = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_queue_byte;
    logic       o_last;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_PAGE_LINES;
    logic [7:0] i_cfg_data = '0;

    // expected printer queue bytes, oldest first
    t_queue_entry queue_bytes_due[$];
    logic [7:0]   step_bytes[$];

    // canonicalizer state and settings as the block should hold them
    logic [7:0] cf_page_lines;
    logic [7:0] cf_line_columns;
    logic       cf_auto_eject;
    logic       cf_raw_mode;
    logic [9:0] lcol;
    logic [7:0] pcol;
    logic [9:0] line_no;
    logic       tof;
    logic       jopen;
    logic       plot_on;
    logic [7:0] last_byte;
    logic [7:0] run_count;

    int fail_count = 0;
    int req_count = 0;
    int byte_count = 0;
    int settings_count = 0;
    int burst_left = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;
    logic [7:0] stall_tick = '0;

    line_printer_canonicalizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_queue_byte (o_queue_byte),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #(6_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic void reset_canonicalizer();
        cf_page_lines = PAGE_LINES_RST;
        cf_line_columns = LINE_COLUMNS_RST;
        cf_auto_eject = 1'b1;
        cf_raw_mode = 1'b0;
        lcol = '0;
        pcol = '0;
        line_no = '0;
        tof = 1'b0;
        jopen = 1'b0;
        plot_on = 1'b0;
        last_byte = '0;
        run_count = '0;
    endfunction

    function automatic void queue_out(input logic [7:0] b);
        if (step_bytes.size() < MAX_OUT)
            step_bytes.push_back(b);
    endfunction

    // repeated bytes become a negative count, flushed before the next differing byte or at the run limit
    function automatic void pack_byte(input logic [7:0] b);
        logic absorbed;
        absorbed = 1'b0;
        if (b == last_byte) begin
            run_count = run_count - 8'd1;
            absorbed = (run_count != RUN_LIMIT);
        end
        if (!absorbed) begin
            last_byte = b;
            tof = 1'b0;
            if (run_count != 8'd0) begin
                queue_out(run_count);
                run_count = '0;
            end
            queue_out(b);
        end
    endfunction

    function automatic void return_carriage();
        plot_on = 1'b0;
        if (pcol > 0)
            pack_byte({1'b0, CH_CR});
        pcol = '0;
        lcol = '0;
    endfunction

    function automatic void canonicalize_char(input logic [6:0] ch);
        logic [6:0]  c;
        logic        is_vt;
        logic        counted;
        logic [10:0] tab_to;
        c = ch;
        case (ch)
            CH_TAB: begin
                tab_to = ({1'b0, lcol} + 11'd8) & ~11'd7;
                lcol = (tab_to > COL_MAX) ? COL_MAX : tab_to[9:0];
            end
            CH_VT, CH_FF, CH_NL: begin
                is_vt = (ch == CH_VT);
                counted = 1'b0;
                // vertical tab past half a page turns into a page eject
                if (is_vt && line_no > (cf_page_lines >> 1))
                    c = CH_FF;
                if (!tof || cf_raw_mode) begin
                    pcol = '0;
                    if (!plot_on) begin
                        counted = 1'b1;
                        if (!is_vt && line_no < LINE_MAX)
                            line_no = line_no + 10'd1;
                    end
                    if (is_vt && !counted && line_no > 0)
                        line_no = line_no - 10'd1;
                    if (line_no >= cf_page_lines && cf_auto_eject && jopen)
                        c = CH_FF;
                    pack_byte({1'b0, c});
                    if (c == CH_FF) begin
                        line_no = '0;
                        tof = 1'b1;
                    end
                end else if (is_vt && line_no > 0) begin
                    line_no = line_no - 10'd1;
                end
                return_carriage();
            end
            CH_CR: return_carriage();
            CH_SO: pack_byte({1'b0, CH_BS});
            CH_BS: begin
                if (lcol > 0)
                    lcol = lcol - 10'd1;
            end
            CH_SP: begin
                if (lcol < COL_MAX)
                    lcol = lcol + 10'd1;
            end
            CH_PLOT: begin
                plot_on = 1'b1;
                pack_byte({1'b0, c});
            end
            default: begin
                // moving left means a carriage return and overstrike
                if (lcol < pcol) begin
                    pack_byte({1'b0, CH_CR});
                    pcol = '0;
                end
                if (lcol < cf_line_columns) begin
                    while (lcol > pcol) begin
                        pack_byte({1'b0, CH_SP});
                        pcol = pcol + 8'd1;
                    end
                    pack_byte({1'b0, c});
                    pcol = pcol + 8'd1;
                end
                if (lcol < COL_MAX)
                    lcol = lcol + 10'd1;
            end
        endcase
    endfunction

    function automatic void canonicalize_request(input logic [1:0] cmd, input logic [6:0] ch);
        t_queue_entry e;
        step_bytes.delete();
        case (cmd)
            CMD_CHAR: begin
                if (jopen)
                    canonicalize_char(ch);
            end
            CMD_OPEN: begin
                if (!jopen) begin
                    jopen = 1'b1;
                    tof = 1'b1;
                    plot_on = 1'b0;
                    run_count = '0;
                    line_no = '0;
                    pcol = '0;
                    if (cf_auto_eject)
                        canonicalize_char(CH_FF);
                    else
                        tof = 1'b0;
                end
            end
            CMD_CLOSE: begin
                if (jopen) begin
                    if (cf_auto_eject)
                        canonicalize_char(CH_FF);
                    jopen = 1'b0;
                    tof = 1'b0;
                end
            end
            default: ;
        endcase
        foreach (step_bytes[k]) begin
            e.qbyte = step_bytes[k];
            e.last = (k == step_bytes.size() - 1);
            queue_bytes_due.push_back(e);
        end
    endfunction

    // settings, accepted requests and accepted queue bytes
    always @(posedge i_clk) begin : queue_check
        t_queue_entry want;
        if (!i_rst_n) begin
            reset_canonicalizer();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGE_LINES:   cf_page_lines = i_cfg_data;
                    CFG_LINE_COLUMNS: cf_line_columns = i_cfg_data;
                    CFG_AUTO_EJECT:   cf_auto_eject = i_cfg_data[0];
                    CFG_RAW_MODE:     cf_raw_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                byte_count++;
                if (queue_bytes_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected queue byte, expected none, actual %02h last %b",
                             $time, o_queue_byte, o_last);
                end else begin
                    want = queue_bytes_due.pop_front();
                    if (o_queue_byte !== want.qbyte) begin
                        fail_count++;
                        $display("%0t: queue_byte mismatch, expected %02h, actual %02h",
                                 $time, want.qbyte, o_queue_byte);
                    end
                    if (o_last !== want.last) begin
                        fail_count++;
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, o_last);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                req_count++;
                canonicalize_request(i_command, i_char_code);
            end
        end
    end

    // receiver: changing stall pattern, plus long hold-offs on demand
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (holds_asked != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_phase == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stall_phase = $urandom_range(16, 96);
                end else begin
                    stall_phase--;
                end
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= stall_tick[2];
                endcase
            end
        end
    end

    task automatic send_req(input logic [1:0] cmd, input logic [6:0] ch);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queue_bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    // a request with no bytes may still be in flight once the queue is empty
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] pl, input logic [7:0] lc,
                              input logic ae, input logic raw);
        cfg_write(CFG_PAGE_LINES, pl);
        cfg_write(CFG_LINE_COLUMNS, lc);
        cfg_write(CFG_AUTO_EJECT, {7'd0, ae});
        cfg_write(CFG_RAW_MODE, {7'd0, raw});
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [6:0] pick_job_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 7'($urandom_range(33, 126));
        else if (r < 57) return CH_SP;
        else if (r < 63) return CH_TAB;
        else if (r < 68) return CH_BS;
        else if (r < 76) return CH_NL;
        else if (r < 80) return CH_CR;
        else if (r < 84) return CH_VT;
        else if (r < 86) return CH_FF;
        else if (r < 88) return CH_SO;
        else if (r < 90) return CH_PLOT;
        else return 7'($urandom_range(0, 127));
    endfunction

    task automatic test_directed();
        send_req(CMD_CHAR, 7'h41);      // no job open yet
        send_req(CMD_CLOSE, 7'h00);
        send_req(CMD_UNUSED, 7'h7F);
        send_req(CMD_OPEN, 7'h00);
        send_req(CMD_OPEN, 7'h00);
        send_req(CMD_CHAR, CH_NL);      // suppressed at top of page
        send_req(CMD_CHAR, CH_VT);
        send_req(CMD_CHAR, 7'h41);
        send_req(CMD_CHAR, 7'h7F);
        send_req(CMD_CHAR, 7'h00);
        send_req(CMD_CHAR, CH_BS);
        send_req(CMD_CHAR, 7'h42);      // overstrike
        send_req(CMD_CHAR, CH_TAB);
        send_req(CMD_CHAR, 7'h43);
        send_req(CMD_CHAR, CH_SP);
        send_req(CMD_CHAR, 7'h44);
        send_req(CMD_CHAR, CH_SO);
        send_req(CMD_CHAR, CH_PLOT);
        send_req(CMD_CHAR, CH_NL);      // not counted in plot mode
        send_req(CMD_CHAR, CH_VT);
        send_req(CMD_CHAR, CH_FF);
        send_req(CMD_CHAR, 7'h45);
        send_req(CMD_CHAR, 7'h45);
        send_req(CMD_CHAR, CH_CR);
        send_req(CMD_CLOSE, 7'h00);
    endtask

    task automatic test_backpressure();
        int k;
        settle();
        set_config(8'd30, 8'd100, 1'b1, 1'b0);
        holds_asked++;
        send_req(CMD_OPEN, 7'h00);
        for (k = 0; k < 30; k++)
            send_req(CMD_CHAR, pick_job_char());
        wait_results();
        for (k = 0; k < 6; k++)
            send_req(CMD_CHAR, 7'($urandom_range(33, 126)));
        send_req(CMD_CLOSE, 7'h00);
    endtask

    // a long run of one byte hits the packing limit, the column counter its ceiling
    task automatic test_counter_limits();
        int k;
        settle();
        set_config(8'd255, 8'd255, 1'b0, 1'b0);
        send_req(CMD_OPEN, 7'h00);
        for (k = 0; k < 130; k++)
            send_req(CMD_CHAR, 7'h41);
        for (k = 0; k < 114; k++)
            send_req(CMD_CHAR, CH_TAB);
        send_req(CMD_CHAR, 7'h5A);
        send_req(CMD_CHAR, CH_SP);
        send_req(CMD_CHAR, CH_BS);
        for (k = 0; k < 4; k++)
            send_req(CMD_CHAR, CH_NL);
        send_req(CMD_CHAR, CH_VT);
        send_req(CMD_CLOSE, 7'h00);
    endtask

    task automatic run_random_jobs(input int n_items);
        int sent;
        int body;
        int k;
        int run_len;
        logic [6:0] ch;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray request of any kind
                send_req(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
            end else begin
                send_req(CMD_OPEN, 7'($urandom));
                sent++;
                body = $urandom_range(2, 12);
                for (k = 0; k < body; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        ch = 7'($urandom_range(33, 126));
                        run_len = $urandom_range(2, 12);
                        repeat (run_len) send_req(CMD_CHAR, ch);
                        sent += run_len;
                    end else begin
                        send_req(CMD_CHAR, pick_job_char());
                        sent++;
                    end
                end
                // sometimes the job stays open and the next open is ignored
                if ($urandom_range(0, 7) != 0) begin
                    send_req(CMD_CLOSE, 7'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 24) == 0)
                    wait_results();
            end
        end
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: set_config(8'd0, 8'd0, 1'b1, 1'b0);
                1: set_config(8'd1, 8'd1, 1'b0, 1'b1);
                2: set_config(8'd255, 8'd255, 1'b1, 1'b1);
                3: set_config(8'd6, 8'd40, 1'b1, 1'b0);
                default: set_config(8'($urandom_range(1, 24)), 8'($urandom_range(1, 255)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            run_random_jobs(10);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_counter_limits();
        test_random_settings();
        settle();
        $display("covered %0d requests and %0d queue bytes over %0d register settings,",
                 req_count, byte_count, settings_count);
        $display("including the column ceiling, page ejects, packing and a long output hold");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
